// ===== hw/rtl/srzc_pkg.sv =====
// Shared types and constants of the sonar range zone controller.
package srzc_pkg;

    localparam int SENSOR_COUNT_DEF = 16;
    localparam int CAPTURE_BITS_DEF = 16;

    localparam int TICKS_W    = 16;
    localparam int IDX_W      = 5;
    localparam int SENSOR_W   = 4;
    localparam int RANGE_W    = 14;
    localparam int CFG_IDX_W  = 1;

    localparam logic [RANGE_W-1:0] DANGER_RESET  = 14'd500;
    localparam logic [RANGE_W-1:0] WARNING_RESET = 14'd1000;

    // mm = floor((ticks*7 + 20) / 40) = floor(floor((ticks*7 + 20) / 8) / 5)
    localparam int ECHO_BIAS  = 20;
    localparam int DIV8_SHIFT = 3;
    localparam int DIV5_MUL_W = 16;
    localparam logic [DIV5_MUL_W-1:0] DIV5_MUL = 16'd52429;
    localparam int DIV5_SHIFT = 18;

    typedef enum logic [1:0] {
        REQ_PULSE = 2'd0,
        REQ_ECHO  = 2'd1,
        REQ_READ  = 2'd2
    } t_req;

    typedef enum logic [1:0] {
        ZONE_DANGER  = 2'd0,
        ZONE_WARNING = 2'd1,
        ZONE_CLEAR   = 2'd2,
        ZONE_NONE    = 2'd3
    } t_zone;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DANGER  = 1'd0,
        CFG_WARNING = 1'd1
    } t_cfg_reg;

endpackage

// ===== hw/rtl/srzc_req_if.sv =====
// Request channel: valid/ready handshake with the request word.
interface srzc_req_if;
    logic                           valid;
    logic                           ready;
    logic [1:0]                     req_type;
    logic [srzc_pkg::IDX_W-1:0]     sensor_index;
    logic [srzc_pkg::TICKS_W-1:0]   capture_ticks;

    modport source (output valid, output req_type, output sensor_index,
                    output capture_ticks, input ready);
    modport sink   (input valid, input req_type, input sensor_index,
                    input capture_ticks, output ready);
endinterface

// ===== hw/rtl/srzc_res_if.sv =====
// Result channel: valid/ready handshake with the result word.
interface srzc_res_if;
    logic                           valid;
    logic                           ready;
    logic                           accepted;
    logic [srzc_pkg::SENSOR_W-1:0]  sensor_out;
    logic [srzc_pkg::RANGE_W-1:0]   range_mm;
    logic                           range_valid;
    logic [1:0]                     zone;
    logic                           led_update;

    modport source (output valid, output accepted, output sensor_out, output range_mm,
                    output range_valid, output zone, output led_update, input ready);
    modport sink   (input valid, input accepted, input sensor_out, input range_mm,
                    input range_valid, input zone, input led_update, output ready);
endinterface

// ===== hw/rtl/sonar_range_zone_controller.sv =====
// Sonar range zone controller: pulse, echo capture and read requests over one sensor bank.
// Each request word gives exactly one result word. A word passes an input register, then
// combinational logic (tick conversion by constant multiply, two threshold compares and one
// access to the per-sensor range store) into the result register, so a request is taken
// every cycle and its result word is presented from the clock edge after the one that took
// the request, unless the result side stalls.
// Only one sensor is in flight at a time: a pulse is refused while a sensor is busy, and
// an echo goes to the busy sensor, is classified against the danger and warning limits,
// stored, and frees the busy mark. Reads return the stored range and whether it was ever
// measured. The user writes limits via the configuration port only while idle; not enforced.
module sonar_range_zone_controller #(
    parameter int SENSOR_COUNT = srzc_pkg::SENSOR_COUNT_DEF,
    parameter int CAPTURE_BITS = srzc_pkg::CAPTURE_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [srzc_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [srzc_pkg::RANGE_W-1:0]     i_cfg_data,
    srzc_req_if.sink                         i_req,
    srzc_res_if.source                       o_res
);
    localparam int SEL_W = (SENSOR_COUNT > 1) ? $clog2(SENSOR_COUNT) : 1;

    // configuration
    logic [srzc_pkg::RANGE_W-1:0] r_danger_limit;
    logic [srzc_pkg::RANGE_W-1:0] r_warning_limit;

    // input register
    logic                          r_in_valid;
    logic [1:0]                    r_req_type;
    logic [srzc_pkg::IDX_W-1:0]    r_sensor_index;
    logic [srzc_pkg::TICKS_W-1:0]  r_capture_ticks;

    // sensor state
    logic                          r_busy;
    logic [SEL_W-1:0]              r_active;
    logic [SENSOR_COUNT-1:0]       r_known;
    logic [srzc_pkg::RANGE_W-1:0]  r_store [SENSOR_COUNT];

    // result register
    logic                          r_out_valid;
    logic                          r_accepted;
    logic [srzc_pkg::SENSOR_W-1:0] r_sensor_out;
    logic [srzc_pkg::RANGE_W-1:0]  r_range_mm;
    logic                          r_range_valid;
    srzc_pkg::t_zone               r_zone;
    logic                          r_led_update;

    logic                          n_accepted;
    logic [srzc_pkg::SENSOR_W-1:0] n_sensor_out;
    logic [srzc_pkg::RANGE_W-1:0]  n_range_mm;
    logic                          n_range_valid;
    srzc_pkg::t_zone               n_zone;
    logic                          n_led_update;

    logic                          in_take;
    logic                          advance;
    logic                          idx_ok;
    logic [SEL_W-1:0]              sel;
    logic [srzc_pkg::RANGE_W-1:0]  echo_mm;
    srzc_pkg::t_zone               echo_zone;
    logic                          start_pulse;
    logic                          finish_echo;

    assign advance     = r_in_valid && (!r_out_valid || o_res.ready);
    assign i_req.ready = !r_in_valid || advance;
    assign in_take     = i_req.valid && i_req.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_danger_limit  <= srzc_pkg::DANGER_RESET;
            r_warning_limit <= srzc_pkg::WARNING_RESET;
        end else if (i_cfg_we) begin
            case (srzc_pkg::t_cfg_reg'(i_cfg_idx))
                srzc_pkg::CFG_DANGER:  r_danger_limit  <= i_cfg_data;
                srzc_pkg::CFG_WARNING: r_warning_limit <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_req_type      <= i_req.req_type;
            r_sensor_index  <= i_req.sensor_index;
            r_capture_ticks <= i_req.capture_ticks;
        end
    end

    srzc_tick_conv #(
        .CAPTURE_BITS (CAPTURE_BITS)
    ) u_conv (
        .i_ticks (r_capture_ticks),
        .o_mm    (echo_mm)
    );

    assign idx_ok = r_sensor_index < srzc_pkg::IDX_W'(SENSOR_COUNT);
    assign sel    = r_sensor_index[SEL_W-1:0];

    always_comb begin
        if (echo_mm < r_danger_limit) begin
            echo_zone = srzc_pkg::ZONE_DANGER;
        end else if (echo_mm < r_warning_limit) begin
            echo_zone = srzc_pkg::ZONE_WARNING;
        end else begin
            echo_zone = srzc_pkg::ZONE_CLEAR;
        end
    end

    always_comb begin
        n_accepted    = 1'b0;
        n_sensor_out  = '0;
        n_range_mm    = '0;
        n_range_valid = 1'b0;
        n_zone        = srzc_pkg::ZONE_NONE;
        n_led_update  = 1'b0;
        start_pulse   = 1'b0;
        finish_echo   = 1'b0;
        case (srzc_pkg::t_req'(r_req_type))
            srzc_pkg::REQ_PULSE: begin
                n_sensor_out = r_sensor_index[srzc_pkg::SENSOR_W-1:0];
                if (idx_ok && !r_busy) begin
                    n_accepted  = 1'b1;
                    start_pulse = 1'b1;
                end
            end
            srzc_pkg::REQ_ECHO: begin
                n_range_mm = echo_mm;
                if (r_busy) begin
                    n_accepted    = 1'b1;
                    n_sensor_out  = srzc_pkg::SENSOR_W'(r_active);
                    n_range_valid = 1'b1;
                    n_zone        = echo_zone;
                    n_led_update  = 1'b1;
                    finish_echo   = 1'b1;
                end
            end
            srzc_pkg::REQ_READ: begin
                n_sensor_out = r_sensor_index[srzc_pkg::SENSOR_W-1:0];
                if (idx_ok) begin
                    n_accepted = 1'b1;
                    if (r_known[sel]) begin
                        n_range_mm    = r_store[sel];
                        n_range_valid = 1'b1;
                    end
                end
            end
            default: ;
        endcase
    end

    // sensor state moves only when the word leaves the input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_active <= '0;
            r_known  <= '0;
        end else if (advance) begin
            if (start_pulse) begin
                r_busy   <= 1'b1;
                r_active <= sel;
            end else if (finish_echo) begin
                r_busy            <= 1'b0;
                r_known[r_active] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && finish_echo) begin
            r_store[r_active] <= echo_mm;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_accepted    <= n_accepted;
            r_sensor_out  <= n_sensor_out;
            r_range_mm    <= n_range_mm;
            r_range_valid <= n_range_valid;
            r_zone        <= n_zone;
            r_led_update  <= n_led_update;
        end
    end

    assign o_res.valid       = r_out_valid;
    assign o_res.accepted    = r_accepted;
    assign o_res.sensor_out  = r_sensor_out;
    assign o_res.range_mm    = r_range_mm;
    assign o_res.range_valid = r_range_valid;
    assign o_res.zone        = r_zone;
    assign o_res.led_update  = r_led_update;
endmodule

// ===== hw/rtl/srzc_tick_conv.sv =====
// Echo timer ticks to millimetres: floor((ticks*7 + 20) / 40) without a divider.
module srzc_tick_conv #(
    parameter int CAPTURE_BITS = srzc_pkg::CAPTURE_BITS_DEF
) (
    input  logic [srzc_pkg::TICKS_W-1:0] i_ticks,
    output logic [srzc_pkg::RANGE_W-1:0] o_mm
);
    localparam int TICK_BITS = (CAPTURE_BITS < srzc_pkg::TICKS_W) ?
                               CAPTURE_BITS : srzc_pkg::TICKS_W;
    localparam int SUM_W  = TICK_BITS + 3;
    localparam int PROD_W = TICK_BITS + srzc_pkg::DIV5_MUL_W;

    logic [TICK_BITS-1:0] ticks;
    logic [SUM_W-1:0]     sum;
    logic [TICK_BITS-1:0] eighths;
    logic [PROD_W-1:0]    prod;

    assign ticks   = i_ticks[TICK_BITS-1:0];
    // ticks*7 as ticks*8 - ticks, plus the rounding bias
    assign sum     = (SUM_W'(ticks) << 3) - SUM_W'(ticks) + SUM_W'(srzc_pkg::ECHO_BIAS);
    assign eighths = sum[SUM_W-1:srzc_pkg::DIV8_SHIFT];
    // divide by 5 with the reciprocal; exact for 16-bit dividends
    assign prod    = PROD_W'(eighths) * PROD_W'(srzc_pkg::DIV5_MUL);
    assign o_mm    = srzc_pkg::RANGE_W'(prod[PROD_W-1:srzc_pkg::DIV5_SHIFT]);
endmodule

// ===== tb/sonar_range_zone_controller_tb.sv =====
// Self-checking testbench of the sonar range zone controller: queued stimulus, predictor, scoreboard.
`timescale 1ns / 100ps

module sonar_range_zone_controller_tb;

    localparam int          SENSORS     = srzc_pkg::SENSOR_COUNT_DEF;
    localparam int          CYCLE_LIMIT = 200000;
    localparam logic [1:0]  REQ_UNUSED  = 2'd3;

    typedef struct packed {
        logic [1:0]                   req_type;
        logic [srzc_pkg::IDX_W-1:0]   sensor_index;
        logic [srzc_pkg::TICKS_W-1:0] ticks;
    } t_sonar_req;

    typedef struct packed {
        logic                          accepted;
        logic [srzc_pkg::SENSOR_W-1:0] sensor;
        logic [srzc_pkg::RANGE_W-1:0]  range_mm;
        logic                          range_valid;
        logic [1:0]                    zone;
        logic                          led_update;
    } t_sonar_result;

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           i_cfg_we;
    logic [srzc_pkg::CFG_IDX_W-1:0] i_cfg_idx;
    logic [srzc_pkg::RANGE_W-1:0]   i_cfg_data;

    srzc_req_if req_if ();
    srzc_res_if res_if ();

    sonar_range_zone_controller uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_req      (req_if.sink),
        .o_res      (res_if.source)
    );

    t_sonar_req    pending_q[$];
    t_sonar_result expected_q[$];

    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned mismatch_count = 0;
    int unsigned cycle_count    = 0;
    logic        req_taken      = 1'b0;

    // predictor state
    logic [srzc_pkg::RANGE_W-1:0]  mdl_danger;
    logic [srzc_pkg::RANGE_W-1:0]  mdl_warning;
    logic                          mdl_busy;
    logic [srzc_pkg::SENSOR_W-1:0] mdl_active;
    logic [srzc_pkg::RANGE_W-1:0]  mdl_range[SENSORS];
    logic                          mdl_known[SENSORS];

    // stimulus-side shadow, used to steer most reads to measured sensors
    logic                          gen_busy = 1'b0;
    logic [srzc_pkg::SENSOR_W-1:0] gen_active = '0;
    logic                          gen_written[SENSORS];

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic t_sonar_result predict_result(input t_sonar_req w);
        t_sonar_result r;
        int unsigned   mm;
        logic [1:0]    zone;
        r = '{accepted: 1'b0, sensor: w.sensor_index[srzc_pkg::SENSOR_W-1:0], range_mm: '0,
              range_valid: 1'b0, zone: srzc_pkg::ZONE_NONE, led_update: 1'b0};
        mm = (32'(w.ticks) * 32'd7 + 32'd20) / 32'd40;
        if (mm > 16383)
            mm = 16383;
        case (w.req_type)
            srzc_pkg::REQ_PULSE: begin
                if (w.sensor_index < SENSORS && !mdl_busy) begin
                    mdl_busy   = 1'b1;
                    mdl_active = w.sensor_index[srzc_pkg::SENSOR_W-1:0];
                    r.accepted = 1'b1;
                end
            end
            srzc_pkg::REQ_ECHO: begin
                r.sensor   = '0;
                r.range_mm = mm[srzc_pkg::RANGE_W-1:0];
                if (mdl_busy) begin
                    if (mm < mdl_danger)
                        zone = srzc_pkg::ZONE_DANGER;
                    else if (mm < mdl_warning)
                        zone = srzc_pkg::ZONE_WARNING;
                    else
                        zone = srzc_pkg::ZONE_CLEAR;
                    mdl_range[mdl_active] = mm[srzc_pkg::RANGE_W-1:0];
                    mdl_known[mdl_active] = 1'b1;
                    mdl_busy      = 1'b0;
                    r.accepted    = 1'b1;
                    r.sensor      = mdl_active;
                    r.range_valid = 1'b1;
                    r.zone        = zone;
                    r.led_update  = 1'b1;
                end
            end
            srzc_pkg::REQ_READ: begin
                if (w.sensor_index < SENSORS) begin
                    r.accepted = 1'b1;
                    if (mdl_known[w.sensor_index[srzc_pkg::SENSOR_W-1:0]]) begin
                        r.range_mm    = mdl_range[w.sensor_index[srzc_pkg::SENSOR_W-1:0]];
                        r.range_valid = 1'b1;
                    end
                end
            end
            default: begin
                r.sensor = '0;
            end
        endcase
        return r;
    endfunction

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            mismatch_count++;
            $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
        end
    endfunction

    // driver: present the next queued request word, hold it until taken
    always @(negedge i_clk) begin
        t_sonar_req nxt;
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
        end else if (!req_if.valid || req_taken) begin
            if (pending_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                nxt = pending_q.pop_front();
                req_if.valid         <= 1'b1;
                req_if.req_type      <= nxt.req_type;
                req_if.sensor_index  <= nxt.sensor_index;
                req_if.capture_ticks <= nxt.ticks;
            end else begin
                req_if.valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        res_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // monitor: predict on each accepted request, check each accepted result
    always @(posedge i_clk) begin
        t_sonar_req    w;
        t_sonar_result want;
        if (!i_rst_n) begin
            mdl_danger  = srzc_pkg::DANGER_RESET;
            mdl_warning = srzc_pkg::WARNING_RESET;
            mdl_busy    = 1'b0;
            mdl_active  = '0;
            for (int i = 0; i < SENSORS; i++) begin
                mdl_range[i] = '0;
                mdl_known[i] = 1'b0;
            end
            req_taken <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    srzc_pkg::CFG_DANGER:  mdl_danger  = i_cfg_data;
                    srzc_pkg::CFG_WARNING: mdl_warning = i_cfg_data;
                    default: ;
                endcase
            end
            if (req_if.valid && req_if.ready) begin
                w.req_type     = req_if.req_type;
                w.sensor_index = req_if.sensor_index;
                w.ticks        = req_if.capture_ticks;
                expected_q.push_back(predict_result(w));
            end
            if (res_if.valid && res_if.ready) begin
                if (expected_q.size() == 0) begin
                    mismatch_count++;
                    $display("%0t: result word expected none actual sensor %0d range %0d",
                             $time, res_if.sensor_out, res_if.range_mm);
                end else begin
                    want = expected_q.pop_front();
                    check_field("accepted", 32'(want.accepted), 32'(res_if.accepted));
                    check_field("sensor_out", 32'(want.sensor), 32'(res_if.sensor_out));
                    check_field("range_mm", 32'(want.range_mm), 32'(res_if.range_mm));
                    check_field("range_valid", 32'(want.range_valid),
                                32'(res_if.range_valid));
                    check_field("zone", 32'(want.zone), 32'(res_if.zone));
                    check_field("led_update", 32'(want.led_update), 32'(res_if.led_update));
                end
            end
            req_taken <= req_if.valid && req_if.ready;
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic queue_req(input logic [1:0] kind, input logic [srzc_pkg::IDX_W-1:0] idx,
                             input logic [srzc_pkg::TICKS_W-1:0] ticks);
        t_sonar_req w;
        w.req_type     = kind;
        w.sensor_index = idx;
        w.ticks        = ticks;
        if (kind == srzc_pkg::REQ_PULSE && idx < SENSORS && !gen_busy) begin
            gen_busy   = 1'b1;
            gen_active = idx[srzc_pkg::SENSOR_W-1:0];
        end else if (kind == srzc_pkg::REQ_ECHO && gen_busy) begin
            gen_written[gen_active] = 1'b1;
            gen_busy = 1'b0;
        end
        pending_q.push_back(w);
    endtask

    // mostly pulse/echo pairs with random content, plus reads and noise
    task automatic queue_random_req();
        logic [srzc_pkg::IDX_W-1:0]   idx;
        logic [srzc_pkg::TICKS_W-1:0] ticks;
        logic [1:0]                   kind;
        logic [srzc_pkg::IDX_W-1:0]   measured[$];
        int unsigned                  roll;
        int unsigned                  pick;
        idx   = srzc_pkg::IDX_W'($urandom);
        ticks = srzc_pkg::TICKS_W'(($urandom_range(0, 1) == 0) ? $urandom_range(0, 8000)
                                                                : $urandom);
        roll  = $urandom_range(0, 99);
        pick  = 0;
        if (gen_busy)
            pick = (roll < 60) ? 1 : (roll < 70) ? 2 : (roll < 85) ? 3 : 4;
        else
            pick = (roll < 55) ? 0 : (roll < 70) ? 3 : 4;
        case (pick)
            0: begin
                kind = srzc_pkg::REQ_PULSE;
                idx  = srzc_pkg::IDX_W'($urandom_range(0, SENSORS - 1));
            end
            1: kind = srzc_pkg::REQ_ECHO;
            2: kind = srzc_pkg::REQ_PULSE;
            3: begin
                kind = srzc_pkg::REQ_READ;
                for (int i = 0; i < SENSORS; i++)
                    if (gen_written[i])
                        measured.push_back(srzc_pkg::IDX_W'(i));
                if (measured.size() == 0 || $urandom_range(0, 3) == 0)
                    idx = srzc_pkg::IDX_W'($urandom_range(0, 31));
                else
                    idx = measured[$urandom_range(0, measured.size() - 1)];
            end
            default: begin
                case ($urandom_range(0, 3))
                    0: kind = srzc_pkg::REQ_ECHO;
                    1: begin
                        kind = srzc_pkg::REQ_PULSE;
                        idx  = srzc_pkg::IDX_W'($urandom_range(SENSORS, 31));
                    end
                    2: kind = REQ_UNUSED;
                    default: begin
                        kind = srzc_pkg::REQ_READ;
                        idx  = srzc_pkg::IDX_W'($urandom_range(SENSORS, 31));
                    end
                endcase
            end
        endcase
        queue_req(kind, idx, ticks);
    endtask

    task automatic queue_random_reqs(input int unsigned count);
        for (int unsigned n = 0; n < count; n++)
            queue_random_req();
    endtask

    // hold until every queued word is taken and every result has come back
    task automatic wait_idle();
        do
            @(posedge i_clk);
        while (pending_q.size() != 0 || req_if.valid || expected_q.size() != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input srzc_pkg::t_cfg_reg idx,
                             input logic [srzc_pkg::RANGE_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = data;
        @(negedge i_clk);
        i_cfg_we   = 1'b0;
    endtask

    task automatic set_limits(input logic [srzc_pkg::RANGE_W-1:0] danger,
                              input logic [srzc_pkg::RANGE_W-1:0] warning);
        write_reg(srzc_pkg::CFG_DANGER, danger);
        write_reg(srzc_pkg::CFG_WARNING, warning);
    endtask

    initial begin
        i_clk                = 1'b0;
        i_rst_n              = 1'b0;
        i_cfg_we             = 1'b0;
        i_cfg_idx            = srzc_pkg::CFG_DANGER;
        i_cfg_data           = '0;
        req_if.valid         = 1'b0;
        req_if.req_type      = srzc_pkg::REQ_PULSE;
        req_if.sensor_index  = '0;
        req_if.capture_ticks = '0;
        res_if.ready         = 1'b0;
        for (int i = 0; i < SENSORS; i++)
            gen_written[i] = 1'b0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: out-of-range requests, unused type, idle echoes, busy refusal
        queue_req(srzc_pkg::REQ_READ, 5'd16, 16'h0000);
        queue_req(srzc_pkg::REQ_READ, 5'd31, 16'hFFFF);
        queue_req(srzc_pkg::REQ_READ, 5'd0, 16'h0000);
        queue_req(srzc_pkg::REQ_READ, 5'd15, 16'hFFFF);
        queue_req(REQ_UNUSED, 5'd31, 16'hFFFF);
        queue_req(srzc_pkg::REQ_ECHO, 5'd0, 16'h0000);
        queue_req(srzc_pkg::REQ_ECHO, 5'd31, 16'hFFFF);
        queue_req(srzc_pkg::REQ_PULSE, 5'd16, 16'h0000);
        queue_req(srzc_pkg::REQ_PULSE, 5'd31, 16'hFFFF);
        queue_req(srzc_pkg::REQ_PULSE, 5'd0, 16'h0000);
        queue_req(srzc_pkg::REQ_PULSE, 5'd5, 16'h0000);
        queue_req(srzc_pkg::REQ_ECHO, 5'd0, 16'h0000);
        queue_req(srzc_pkg::REQ_PULSE, 5'd15, 16'h0000);
        queue_req(srzc_pkg::REQ_ECHO, 5'd0, 16'hFFFF);
        queue_req(srzc_pkg::REQ_READ, 5'd0, 16'h0000);
        queue_req(srzc_pkg::REQ_READ, 5'd15, 16'h0000);
        queue_req(srzc_pkg::REQ_READ, 5'd7, 16'h0000);
        // ranges on either side of both default limits
        queue_req(srzc_pkg::REQ_PULSE, 5'd3, 16'h0000);
        queue_req(srzc_pkg::REQ_ECHO, 5'd0, 16'd2849);
        queue_req(srzc_pkg::REQ_PULSE, 5'd4, 16'h0000);
        queue_req(srzc_pkg::REQ_ECHO, 5'd0, 16'd2855);
        queue_req(srzc_pkg::REQ_PULSE, 5'd5, 16'h0000);
        queue_req(srzc_pkg::REQ_ECHO, 5'd0, 16'd5706);
        queue_req(srzc_pkg::REQ_PULSE, 5'd6, 16'h0000);
        queue_req(srzc_pkg::REQ_ECHO, 5'd0, 16'd5712);
        queue_req(srzc_pkg::REQ_READ, 5'd3, 16'h0000);
        queue_random_reqs(100);
        wait_idle();

        set_limits('0, '1);
        send_idle_pct  = 47;
        recv_stall_pct = 0;
        queue_random_reqs(200);
        wait_idle();

        set_limits('1, '0);
        send_idle_pct  = 0;
        recv_stall_pct = 47;
        queue_random_reqs(200);
        wait_idle();

        set_limits(14'd300, 14'd3000);
        send_idle_pct  = 11;
        recv_stall_pct = 11;
        queue_random_reqs(100);
        wait_idle();
        queue_random_reqs(100);
        wait_idle();

        set_limits(srzc_pkg::RANGE_W'($urandom_range(0, 16383)),
                   srzc_pkg::RANGE_W'($urandom_range(0, 16383)));
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        queue_random_reqs(200);
        wait_idle();

        repeat (8) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
